### hw/rtl/tod_pkg.sv
// tod_pkg: shared types and constants for the triangle outline rasterizer
// beat structs for the req and rsp channels, csr indexes, action codes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tod_pkg;

   localparam int COORD_W = 16;
   localparam int FRAME_W = 13;
   localparam int COLOR_W = 32;
   localparam int ADDR_W  = 24;
   localparam int CSR_IDX_W = 1;

   // clip compare width and address product width
   localparam int CMP_W = ((COORD_W > FRAME_W) ? COORD_W : FRAME_W) + 1;
   localparam int MUL_W = COORD_W + FRAME_W + 1;

   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_TICK = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 1'd1;

   localparam logic [FRAME_W-1:0] FRAME_WIDTH_RESET  = 13'd800;
   localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RESET = 13'd600;

   typedef struct packed {
      logic                      action;
      logic signed [COORD_W-1:0] vertex0_x;
      logic signed [COORD_W-1:0] vertex0_y;
      logic signed [COORD_W-1:0] vertex1_x;
      logic signed [COORD_W-1:0] vertex1_y;
      logic signed [COORD_W-1:0] vertex2_x;
      logic signed [COORD_W-1:0] vertex2_y;
      logic [COLOR_W-1:0]        line_color;
   } req_beat_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic                      write_enable;
      logic [ADDR_W-1:0]         frame_address;
      logic [COLOR_W-1:0]        pixel_color;
      logic                      last_point;
   } rsp_beat_type;

endpackage

`default_nettype wire

### hw/rtl/tod_div.sv
// tod_div: serial restoring divider, one quotient bit per cycle
// computes (dividend << FRAC_BITS) / divisor for dividend <= divisor
// depends on tod_pkg
`timescale 1ns / 1ps
`default_nettype none

module tod_div
   import tod_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [COORD_W-1:0]   dividend,
   input  wire logic [COORD_W-1:0]   divisor,
   output logic                      done,
   output logic [FRAC_BITS:0]        quotient
);

   localparam int CNT_W = $clog2(FRAC_BITS + 1);

   logic                 running_ff, running_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [COORD_W-1:0]   rem_ff, rem_in;
   logic [COORD_W-1:0]   den_ff, den_in;
   logic [FRAC_BITS:0]   q_ff, q_in;

   logic [COORD_W:0]     trial;
   logic [COORD_W:0]     diff;
   logic                 ge;

   always_comb begin
      if (cnt_ff == '0) begin
         trial = {1'b0, rem_ff};
      end else begin
         trial = {rem_ff, 1'b0};
      end
      ge   = trial >= {1'b0, den_ff};
      diff = trial - {1'b0, den_ff};
   end

   always_comb begin
      running_in = running_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      den_in     = den_ff;
      q_in       = q_ff;
      if (start) begin
         running_in = 1'b1;
         cnt_in     = '0;
         rem_in     = dividend;
         den_in     = divisor;
         q_in       = '0;
      end else if (running_ff) begin
         rem_in = ge ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
         q_in   = {q_ff[FRAC_BITS-1:0], ge};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(FRAC_BITS)) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
         cnt_ff     <= '0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
         cnt_ff     <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

`default_nettype wire

### hw/rtl/triangle_outline_dda_raster_core.sv
// triangle outline rasterizer: walks edges v0-v1, v1-v2, v2-v0 with a fixed point dda
// load: req stalls until edge setup through the serial divider tod_div is done
// tick: S_POINT then S_EMIT, which waits on rsp_stall; an edge's last point runs the next setup
// the rsp register holds a point while the next beat is taken; one beat in flight at a time
// synchronous active-high reset: idle, frame 800 x 600, nothing drawing
// depends on tod_pkg and tod_div
`timescale 1ns / 1ps
`default_nettype none

module triangle_outline_dda_raster_core
   import tod_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_beat_type          req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_beat_type               rsp_data,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [FRAME_W-1:0]    csr_wdata
);

   localparam int PW = COORD_W + 2 + FRAC_BITS;
   localparam int SW = FRAC_BITS + 2;

   localparam logic [1:0] EDGE_A = 2'd0;
   localparam logic [1:0] EDGE_B = 2'd1;
   localparam logic [1:0] EDGE_C = 2'd2;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_POINT = 6'b000010,
      S_EMIT  = 6'b000100,
      S_SETUP = 6'b001000,
      S_DIVX  = 6'b010000,
      S_DIVY  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic                      busy_ff, busy_in;
   logic [1:0]                edge_ff, edge_in;
   logic                      pend_ff, pend_in;
   logic                      last_ff, last_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [FRAME_W-1:0]        fw_ff, fw_in;
   logic [FRAME_W-1:0]        fh_ff, fh_in;

   logic signed [COORD_W-1:0] v0x_ff, v0y_ff, v1x_ff, v1y_ff, v2x_ff, v2y_ff;
   logic signed [COORD_W-1:0] v0x_in, v0y_in, v1x_in, v1y_in, v2x_in, v2y_in;
   logic [COLOR_W-1:0]        color_ff, color_in;
   logic signed [PW-1:0]      pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic signed [SW-1:0]      step_x_ff, step_x_in, step_y_ff, step_y_in;
   logic [COORD_W-1:0]        steps_ff, steps_in;
   logic                      dx_neg_ff, dx_neg_in, dy_neg_ff, dy_neg_in;
   logic [COORD_W-1:0]        dy_mag_ff, dy_mag_in;
   logic [COORD_W-1:0]        n_ff, n_in;
   logic signed [COORD_W-1:0] px_ff, px_in, py_ff, py_in;
   rsp_beat_type              rsp_data_ff, rsp_data_in;

   // edge setup
   logic signed [COORD_W-1:0] xa, ya, xb, yb;
   logic signed [COORD_W:0]   dx, dy;
   logic [COORD_W:0]          dx_abs, dy_abs;
   logic [COORD_W-1:0]        dx_mag, dy_mag, n_cur;

   // rounding
   logic [PW-1:0]             mag_x, mag_y, rnd_x, rnd_y, half;
   logic [COORD_W-1:0]        rx, ry;

   // clip and address
   logic                      in_frame;
   logic [MUL_W-1:0]          addr_full;

   // divider
   logic                      div_start, div_done;
   logic [COORD_W-1:0]        div_dividend, div_divisor;
   logic [FRAC_BITS:0]        div_q;
   logic signed [SW-1:0]      q_signed;

   logic                      req_take, rsp_free;

   tod_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      case (edge_ff)
         EDGE_A: begin
            xa = v0x_ff; ya = v0y_ff; xb = v1x_ff; yb = v1y_ff;
         end
         EDGE_B: begin
            xa = v1x_ff; ya = v1y_ff; xb = v2x_ff; yb = v2y_ff;
         end
         default: begin
            xa = v2x_ff; ya = v2y_ff; xb = v0x_ff; yb = v0y_ff;
         end
      endcase
      dx     = {xb[COORD_W-1], xb} - {xa[COORD_W-1], xa};
      dy     = {yb[COORD_W-1], yb} - {ya[COORD_W-1], ya};
      dx_abs = dx[COORD_W] ? -dx : dx;
      dy_abs = dy[COORD_W] ? -dy : dy;
      dx_mag = dx_abs[COORD_W-1:0];
      dy_mag = dy_abs[COORD_W-1:0];
      n_cur  = (dx_mag >= dy_mag) ? dx_mag : dy_mag;
   end

   // round half away from zero
   always_comb begin
      half  = PW'(1) << (FRAC_BITS - 1);
      mag_x = pos_x_ff[PW-1] ? -pos_x_ff : pos_x_ff;
      mag_y = pos_y_ff[PW-1] ? -pos_y_ff : pos_y_ff;
      rnd_x = (mag_x + half) >> FRAC_BITS;
      rnd_y = (mag_y + half) >> FRAC_BITS;
      rx    = pos_x_ff[PW-1] ? -rnd_x[COORD_W-1:0] : rnd_x[COORD_W-1:0];
      ry    = pos_y_ff[PW-1] ? -rnd_y[COORD_W-1:0] : rnd_y[COORD_W-1:0];
   end

   always_comb begin
      in_frame = !px_ff[COORD_W-1] && !py_ff[COORD_W-1]
                 && (CMP_W'(px_ff) < CMP_W'(fw_ff))
                 && (CMP_W'(py_ff) < CMP_W'(fh_ff));
      addr_full = MUL_W'(fw_ff) * MUL_W'(py_ff[COORD_W-2:0])
                  + MUL_W'(px_ff[COORD_W-2:0]);
   end

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   assign div_start    = ((state_ff == S_SETUP) && (n_cur != '0))
                         || ((state_ff == S_DIVX) && div_done);
   assign div_dividend = (state_ff == S_SETUP) ? dx_mag : dy_mag_ff;
   assign div_divisor  = (state_ff == S_SETUP) ? n_cur : n_ff;
   assign q_signed     = SW'(div_q);

   always_comb begin
      state_in     = state_ff;
      busy_in      = busy_ff;
      edge_in      = edge_ff;
      pend_in      = pend_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff;
      fw_in        = fw_ff;
      fh_in        = fh_ff;
      v0x_in = v0x_ff; v0y_in = v0y_ff; v1x_in = v1x_ff;
      v1y_in = v1y_ff; v2x_in = v2x_ff; v2y_in = v2y_ff;
      color_in     = color_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      step_x_in    = step_x_ff;
      step_y_in    = step_y_ff;
      steps_in     = steps_ff;
      dx_neg_in    = dx_neg_ff;
      dy_neg_in    = dy_neg_ff;
      dy_mag_in    = dy_mag_ff;
      n_in         = n_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  fw_in = csr_wdata;
            CSR_FRAME_HEIGHT: fh_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (req_data.action == ACT_LOAD) begin
                  v0x_in   = req_data.vertex0_x;
                  v0y_in   = req_data.vertex0_y;
                  v1x_in   = req_data.vertex1_x;
                  v1y_in   = req_data.vertex1_y;
                  v2x_in   = req_data.vertex2_x;
                  v2y_in   = req_data.vertex2_y;
                  color_in = req_data.line_color;
                  edge_in  = EDGE_A;
                  busy_in  = 1'b1;
                  state_in = S_SETUP;
               end else if (busy_ff) begin
                  state_in = S_POINT;
               end
            end
         end
         S_POINT: begin
            px_in   = rx;
            py_in   = ry;
            last_in = 1'b0;
            pend_in = 1'b0;
            if (steps_ff == '0) begin
               if (edge_ff == EDGE_C) begin
                  last_in = 1'b1;
                  busy_in = 1'b0;
               end else begin
                  edge_in = edge_ff + 2'd1;
                  pend_in = 1'b1;
               end
            end else begin
               pos_x_in = pos_x_ff + PW'(step_x_ff);
               pos_y_in = pos_y_ff + PW'(step_y_ff);
               steps_in = steps_ff - COORD_W'(1);
            end
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.point_x        = px_ff;
               rsp_data_in.point_y        = py_ff;
               rsp_data_in.write_enable   = in_frame;
               rsp_data_in.frame_address  = in_frame ? addr_full[ADDR_W-1:0] : '0;
               rsp_data_in.pixel_color    = color_ff;
               rsp_data_in.last_point     = last_ff;
               state_in = pend_ff ? S_SETUP : S_IDLE;
            end
         end
         S_SETUP: begin
            pos_x_in  = {{2{xa[COORD_W-1]}}, xa, FRAC_BITS'(0)};
            pos_y_in  = {{2{ya[COORD_W-1]}}, ya, FRAC_BITS'(0)};
            steps_in  = n_cur;
            n_in      = n_cur;
            dx_neg_in = dx[COORD_W];
            dy_neg_in = dy[COORD_W];
            dy_mag_in = dy_mag;
            if (n_cur == '0) begin
               step_x_in = '0;
               step_y_in = '0;
               state_in  = S_IDLE;
            end else begin
               state_in  = S_DIVX;
            end
         end
         S_DIVX: begin
            if (div_done) begin
               step_x_in = dx_neg_ff ? -q_signed : q_signed;
               state_in  = S_DIVY;
            end
         end
         S_DIVY: begin
            if (div_done) begin
               step_y_in = dy_neg_ff ? -q_signed : q_signed;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         busy_ff      <= 1'b0;
         edge_ff      <= EDGE_A;
         pend_ff      <= 1'b0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fw_ff        <= FRAME_WIDTH_RESET;
         fh_ff        <= FRAME_HEIGHT_RESET;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         edge_ff      <= edge_in;
         pend_ff      <= pend_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
         fw_ff        <= fw_in;
         fh_ff        <= fh_in;
      end
   end

   always_ff @(posedge clock) begin
      v0x_ff      <= v0x_in;
      v0y_ff      <= v0y_in;
      v1x_ff      <= v1x_in;
      v1y_ff      <= v1y_in;
      v2x_ff      <= v2x_in;
      v2y_ff      <= v2y_in;
      color_ff    <= color_in;
      pos_x_ff    <= pos_x_in;
      pos_y_ff    <= pos_y_in;
      step_x_ff   <= step_x_in;
      step_y_ff   <= step_y_in;
      steps_ff    <= steps_in;
      dx_neg_ff   <= dx_neg_in;
      dy_neg_ff   <= dy_neg_in;
      dy_mag_ff   <= dy_mag_in;
      n_ff        <= n_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
